// ===== hw/rtl/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, keyword tables and helpers for the text command decoder.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam int NumKeys   = 6;
   localparam int KeyLenMax = 9;

   typedef logic [$clog2(NumKeys)-1:0]     key_idx_type;
   typedef logic [$clog2(KeyLenMax+1)-1:0] match_type;

   // keyword index order is also the result priority order
   localparam key_idx_type KEY_OPEN     = 3'd0;
   localparam key_idx_type KEY_CLOSE    = 3'd1;
   localparam key_idx_type KEY_LEVEL    = 3'd2;
   localparam key_idx_type KEY_COMM_OK  = 3'd3;
   localparam key_idx_type KEY_MAX      = 3'd4;
   localparam key_idx_type KEY_START_OK = 3'd5;

   localparam logic [2:0] CODE_NONE     = 3'd0;
   localparam logic [2:0] CODE_OPEN     = 3'd1;
   localparam logic [2:0] CODE_CLOSE    = 3'd2;
   localparam logic [2:0] CODE_LEVEL    = 3'd3;
   localparam logic [2:0] CODE_COMM_OK  = 3'd4;
   localparam logic [2:0] CODE_MAX      = 3'd5;
   localparam logic [2:0] CODE_START_OK = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [7:0] ValueMax = 8'd100;
   localparam logic [7:0] AccMax   = 8'd255;

   localparam logic [7:0] KEY_TEXT [NumKeys][KeyLenMax] = '{
      '{"O", "p", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "l", "o", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"L", "e", "v", "e", "l", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "o", "m", "m", "#", "O", "K", "!", 8'h00},
      '{"M", "a", "x", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "t", "a", "r", "t", "#", "O", "K", "!"}
   };

   localparam match_type KEY_LEN [NumKeys] = '{
      4'd4, 4'd5, 4'd5, 4'd8, 4'd3, 4'd9
   };

   typedef enum logic [1:0] {
      PHASE_WAIT_HASH,
      PHASE_IN_VALUE,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      NUM_START,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_END
   } num_state_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
   } req_byte_type;

   // none of the keywords has a prefix with a border, so a mismatch falls
   // back to either an empty match or a match of the first letter
   function automatic match_type next_match(input key_idx_type k,
                                            input match_type m,
                                            input logic [7:0] c);
      match_type res;
      if (c == KEY_TEXT[k][m]) begin
         res = m + match_type'(1);
      end else if (c == KEY_TEXT[k][0]) begin
         res = match_type'(1);
      end else begin
         res = '0;
      end
      return res;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

// ===== hw/rtl/tcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// tcd_in_stage
// Input register: holds one message byte until the parser takes it.
// ----------------------------------------------------------------------------
module tcd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_in,
   input  logic                  req_last,
   input  logic                  take,
   output logic                  byte_valid,
   output tcd_pkg::req_byte_type byte_data
);

   logic                  valid_ff;
   logic                  valid_in;
   tcd_pkg::req_byte_type data_ff;
   logic                  load;

   // the register frees up in the same cycle that the parser takes it
   assign load      = !valid_ff || take;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         data_ff.char_in <= req_char_in;
         data_ff.last    <= req_last;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ===== hw/rtl/tcd_parser.sv =====
// ----------------------------------------------------------------------------
// tcd_parser
// Keyword matchers, value parser and result register.
// ----------------------------------------------------------------------------
module tcd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  tcd_pkg::req_byte_type byte_data,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_code,
   output logic [6:0]            rsp_value
);

   tcd_pkg::match_type     match_ff   [tcd_pkg::NumKeys];
   tcd_pkg::match_type     match_in   [tcd_pkg::NumKeys];
   tcd_pkg::match_type     match_cand [tcd_pkg::NumKeys];
   tcd_pkg::match_type     match_upd  [tcd_pkg::NumKeys];
   logic [tcd_pkg::NumKeys-1:0] found_ff, found_in, found_upd;
   tcd_pkg::phase_type     phase_ff, phase_in, phase_upd;
   tcd_pkg::num_state_type num_ff, num_in, num_upd;
   logic [7:0]             acc_ff, acc_in, acc_upd;
   logic                   term_ff, term_in, term_upd;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             code_ff, code_in;
   logic [6:0]             value_ff, value_in;

   logic [7:0]             c;
   logic [11:0]            acc_next_wide;
   logic                   is_digit;

   assign c        = byte_data.char_in;
   assign is_digit = (c >= tcd_pkg::CHAR_ZERO) && (c <= tcd_pkg::CHAR_NINE);
   // '0'..'9' are 0x30..0x39, so the low nibble is the digit
   assign acc_next_wide = {4'd0, acc_ff} * 12'd10 + {8'd0, c[3:0]};

   // a closing request waits only while the result register is full and held
   assign take = byte_valid && (!byte_data.last || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int k = 0; k < tcd_pkg::NumKeys; k++) begin
         match_cand[k] = tcd_pkg::next_match(tcd_pkg::key_idx_type'(k), match_ff[k], c);
      end
   end

   // state after this byte
   always_comb begin
      match_upd = match_ff;
      found_upd = found_ff;
      phase_upd = phase_ff;
      num_upd   = num_ff;
      acc_upd   = acc_ff;
      term_upd  = term_ff;
      if (!term_ff) begin
         if (c == tcd_pkg::CHAR_NUL) begin
            term_upd = 1'b1;
         end else begin
            for (int k = 0; k < tcd_pkg::NumKeys; k++) begin
               if (!found_ff[k]) begin
                  if (match_cand[k] == tcd_pkg::KEY_LEN[k]) begin
                     found_upd[k] = 1'b1;
                     match_upd[k] = '0;
                  end else begin
                     match_upd[k] = match_cand[k];
                  end
               end
            end
            unique case (phase_ff)
               tcd_pkg::PHASE_WAIT_HASH: begin
                  if (c == tcd_pkg::CHAR_HASH) begin
                     phase_upd = tcd_pkg::PHASE_IN_VALUE;
                  end
               end
               tcd_pkg::PHASE_IN_VALUE: begin
                  if (c == tcd_pkg::CHAR_BANG) begin
                     phase_upd = tcd_pkg::PHASE_DONE;
                  end else if (num_ff != tcd_pkg::NUM_END) begin
                     priority if (is_digit) begin
                        acc_upd = (acc_next_wide > {4'd0, tcd_pkg::AccMax}) ?
                                  tcd_pkg::AccMax : acc_next_wide[7:0];
                        num_upd = tcd_pkg::NUM_DIGITS;
                     end else if (num_ff == tcd_pkg::NUM_START && tcd_pkg::is_space(c)) begin
                        num_upd = num_ff;
                     end else if (num_ff == tcd_pkg::NUM_START && c == tcd_pkg::CHAR_PLUS) begin
                        num_upd = tcd_pkg::NUM_SIGN;
                     end else if (num_ff == tcd_pkg::NUM_START && c == tcd_pkg::CHAR_MINUS) begin
                        // negative numbers clamp to zero
                        acc_upd = '0;
                        num_upd = tcd_pkg::NUM_END;
                     end else begin
                        num_upd = tcd_pkg::NUM_END;
                     end
                  end
               end
               tcd_pkg::PHASE_DONE: begin
                  phase_upd = phase_ff;
               end
               default: begin
                  phase_upd = phase_ff;
               end
            endcase
         end
      end
   end

   // result for a closing byte
   always_comb begin
      code_in = tcd_pkg::CODE_NONE;
      for (int k = tcd_pkg::NumKeys - 1; k >= 0; k--) begin
         if (found_upd[k]) begin
            code_in = 3'(k + 1);
         end
      end
      value_in = '0;
      if ((code_in == tcd_pkg::CODE_OPEN || code_in == tcd_pkg::CODE_CLOSE ||
           code_in == tcd_pkg::CODE_LEVEL || code_in == tcd_pkg::CODE_MAX) &&
          phase_upd != tcd_pkg::PHASE_WAIT_HASH) begin
         value_in = (acc_upd > tcd_pkg::ValueMax) ? tcd_pkg::ValueMax[6:0] : acc_upd[6:0];
      end
   end

   // a closing byte returns all parser state to idle
   always_comb begin
      match_in = match_ff;
      found_in = found_ff;
      phase_in = phase_ff;
      num_in   = num_ff;
      acc_in   = acc_ff;
      term_in  = term_ff;
      if (take) begin
         if (byte_data.last) begin
            for (int k = 0; k < tcd_pkg::NumKeys; k++) begin
               match_in[k] = '0;
            end
            found_in = '0;
            phase_in = tcd_pkg::PHASE_WAIT_HASH;
            num_in   = tcd_pkg::NUM_START;
            acc_in   = '0;
            term_in  = 1'b0;
         end else begin
            match_in = match_upd;
            found_in = found_upd;
            phase_in = phase_upd;
            num_in   = num_upd;
            acc_in   = acc_upd;
            term_in  = term_upd;
         end
      end
   end

   always_comb begin
      if (take && byte_data.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < tcd_pkg::NumKeys; k++) begin
            match_ff[k] <= '0;
         end
         found_ff     <= '0;
         phase_ff     <= tcd_pkg::PHASE_WAIT_HASH;
         num_ff       <= tcd_pkg::NUM_START;
         acc_ff       <= '0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         match_ff     <= match_in;
         found_ff     <= found_in;
         phase_ff     <= phase_in;
         num_ff       <= num_in;
         acc_ff       <= acc_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && byte_data.last) begin
         code_ff  <= code_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = code_ff;
   assign rsp_value = value_ff;

endmodule

// ===== hw/rtl/text_command_decoder.sv =====
// A request's last byte is held in the input register until the parser takes it, and its
// result is then registered in the result register, which holds it until it is taken.
// Throughput: one byte per cycle; the input register and the result register
// let bytes keep flowing while a finished result waits to be taken.
// Only a last byte waits when the result register is full and stalled.
// Reset (synchronous, active high) empties both registers and clears all parser state.
// ----------------------------------------------------------------------------
// text_command_decoder
// Byte-serial keyword and value decoder for short text command messages.
// ----------------------------------------------------------------------------
module text_command_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_code,
   output logic [6:0] rsp_value
);

   logic                  byte_valid;
   tcd_pkg::req_byte_type byte_data;
   logic                  take;

   tcd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .req_last    (req_last),
      .take        (take),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   tcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_code   (rsp_code),
      .rsp_value  (rsp_value)
   );

endmodule
